// File: rtl/core/dsti_pkg.sv
// Package for the digit string to integer parser.
// Holds the control-state struct, character and radix constants, and the digit decoder.
// No dependencies.
package dsti_pkg;

  // Character codes
  localparam logic [15:0] CHAR_ZERO  = 16'h0030;
  localparam logic [15:0] CHAR_NINE  = 16'h0039;
  localparam logic [15:0] CHAR_UC_A  = 16'h0041;
  localparam logic [15:0] CHAR_UC_Z  = 16'h005A;
  localparam logic [15:0] CHAR_LC_A  = 16'h0061;
  localparam logic [15:0] CHAR_LC_Z  = 16'h007A;
  localparam logic [15:0] CHAR_LC_X  = 16'h0078;
  localparam logic [15:0] CHAR_MINUS = 16'h002D;
  localparam logic [15:0] CHAR_PLUS  = 16'h002B;

  // Radix codes
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] RADIX_DEC  = 6'd10;
  localparam logic [5:0] RADIX_HEX  = 6'd16;

  // Digit value used for characters that are not alphanumeric
  localparam logic [6:0] DIGIT_NONE = 7'd99;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [1:0] CHARS_SAT = 2'd3;

  // Per-string control state (the accumulator lives beside it)
  typedef struct packed {
    logic [5:0] active_radix;
    logic [1:0] chars_seen;
    logic       negative_flag;
    logic       error_flag;
    logic       prefix_zero_pending;
    logic       sign_slot_open;
  } dsti_ctrl_t;

  localparam dsti_ctrl_t CTRL_RESET = '{
    active_radix:        RADIX_AUTO,
    chars_seen:          2'd0,
    negative_flag:       1'b0,
    error_flag:          1'b0,
    prefix_zero_pending: 1'b0,
    sign_slot_open:      1'b0
  };

  // Digit value of a character, DIGIT_NONE if not 0-9, A-Z or a-z
  function automatic logic [6:0] digit_of(input logic [15:0] ch);
    logic [15:0] diff;
    begin
      diff = 16'd0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        diff = ch - CHAR_ZERO;
        digit_of = diff[6:0];
      end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
        diff = ch - CHAR_UC_A + 16'd10;
        digit_of = diff[6:0];
      end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
        diff = ch - CHAR_LC_A + 16'd10;
        digit_of = diff[6:0];
      end else begin
        digit_of = DIGIT_NONE;
      end
    end
  endfunction

endpackage

// File: rtl/core/dsti_step.sv
// Next-state logic of the parser for one character request.
// Depends on dsti_pkg. Purely combinational: one multiply by the radix and one add.
module dsti_step #(
  parameter int VALUE_BITS = 64
) (
  input  dsti_pkg::dsti_ctrl_t    ctrl_i,
  input  logic [VALUE_BITS-1:0]   acc_i,
  input  logic [15:0]             character_i,
  input  logic [5:0]              radix_request_i,
  input  logic                    last_char_i,
  input  logic                    empty_string_i,
  output dsti_pkg::dsti_ctrl_t    ctrl_o,
  output logic [VALUE_BITS-1:0]   acc_o,
  output logic                    emit_o,
  output logic [VALUE_BITS-1:0]   value_o,
  output logic                    status_o
);

  dsti_pkg::dsti_ctrl_t  c;
  logic                  consumed;
  logic [6:0]            digit;
  logic [VALUE_BITS-1:0] digit_ext;
  logic [VALUE_BITS-1:0] addend;
  logic [VALUE_BITS-1:0] product;
  logic [VALUE_BITS-1:0] acc_new;

  // Digit decode
  assign digit     = dsti_pkg::digit_of(character_i);
  assign digit_ext = {{(VALUE_BITS-7){1'b0}}, digit};

  always_comb begin
    c        = ctrl_i;
    consumed = 1'b0;
    acc_new  = acc_i;
    product  = '0;
    addend   = '0;
    emit_o   = 1'b0;
    value_o  = '0;
    status_o = dsti_pkg::STATUS_OK;

    // Radix selection on the first character, "0x" prefix check on the second
    if (ctrl_i.chars_seen == 2'd0) begin
      c.sign_slot_open = 1'b1;
      if (radix_request_i == dsti_pkg::RADIX_AUTO) begin
        c.active_radix        = dsti_pkg::RADIX_DEC;
        c.prefix_zero_pending = (character_i == dsti_pkg::CHAR_ZERO);
      end else if (radix_request_i < dsti_pkg::RADIX_MIN ||
                   radix_request_i > dsti_pkg::RADIX_MAX) begin
        c.error_flag = 1'b1;
      end else begin
        c.active_radix = radix_request_i;
      end
    end else if (ctrl_i.prefix_zero_pending) begin
      c.prefix_zero_pending = 1'b0;
      if (!ctrl_i.error_flag && character_i == dsti_pkg::CHAR_LC_X) begin
        c.active_radix   = dsti_pkg::RADIX_HEX;
        c.sign_slot_open = 1'b1;
        consumed         = 1'b1;
      end
    end

    // Sign or digit; digits are negated once '-' was seen so the
    // accumulator always holds the signed result
    if (!c.error_flag && !consumed) begin
      if (c.sign_slot_open &&
          (character_i == dsti_pkg::CHAR_MINUS || character_i == dsti_pkg::CHAR_PLUS)) begin
        c.negative_flag  = (character_i == dsti_pkg::CHAR_MINUS);
        c.sign_slot_open = 1'b0;
      end else begin
        c.sign_slot_open = 1'b0;
        if (digit >= {1'b0, c.active_radix}) begin
          c.error_flag = 1'b1;
        end else begin
          product = VALUE_BITS'(acc_i * {{(VALUE_BITS-6){1'b0}}, c.active_radix});
          addend  = c.negative_flag ? -digit_ext : digit_ext;
          acc_new = product + addend;
        end
      end
    end

    if (c.chars_seen != dsti_pkg::CHARS_SAT) begin
      c.chars_seen = c.chars_seen + 2'd1;
    end

    ctrl_o = c;
    acc_o  = acc_new;

    // Result on an empty string or on the last character; state clears
    if (empty_string_i) begin
      emit_o   = 1'b1;
      status_o = dsti_pkg::STATUS_ERR;
      ctrl_o   = dsti_pkg::CTRL_RESET;
      acc_o    = '0;
    end else if (last_char_i) begin
      emit_o   = 1'b1;
      status_o = c.error_flag ? dsti_pkg::STATUS_ERR : dsti_pkg::STATUS_OK;
      value_o  = c.error_flag ? '0 : acc_new;
      ctrl_o   = dsti_pkg::CTRL_RESET;
      acc_o    = '0;
    end
  end

endmodule

// File: rtl/core/digit_string_to_integer_top.sv
// Top level of the streaming digit string to integer parser.
// Depends on dsti_pkg and dsti_step.
//
// Usage:
//  - Input channel (in_valid/in_ready): one character request per string
//    character. in_radix_request is used on a string's first request only
//    (0 = auto, 2..36 = radix). in_last_char marks the final character;
//    in_empty_string carries no character and yields an invalid result at once.
//  - Result channel (out_valid/out_ready): one request per finished string,
//    out_parsed_value (mod 2^VALUE_BITS, signed by a leading '-') and
//    out_parse_status (0 ok, 1 invalid; value is 0 when invalid).
//  - Throughput: one character per cycle while the result channel does not
//    stall. The parse state loop is a single multiply by the radix plus an add.
//  - Result path: the request that ends the string goes through the input
//    register, then the result register, before it shows on out_valid.
//  - Reset: rst_n low clears all parse state and both stages; no string is
//    in progress afterward.
//  - Stall: while out_ready is low with a result held, one more character
//    is taken into the input register, then in_ready drops until the
//    result is taken.
module digit_string_to_integer_top #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_character,
  input  logic [5:0]            in_radix_request,
  input  logic                  in_last_char,
  input  logic                  in_empty_string,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_parsed_value,
  output logic                  out_parse_status
);

  // Input register
  logic        s1_valid_r;
  logic [15:0] s1_character_r;
  logic [5:0]  s1_radix_request_r;
  logic        s1_last_char_r;
  logic        s1_empty_string_r;

  // Parse state
  dsti_pkg::dsti_ctrl_t  ctrl_r, ctrl_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;

  // Result register
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_status_r;

  logic                  advance;
  logic                  step_emit;
  logic [VALUE_BITS-1:0] step_value;
  logic                  step_status;

  // The input stage moves whenever the result register is free or drains
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_character_r     <= in_character;
      s1_radix_request_r <= in_radix_request;
      s1_last_char_r     <= in_last_char;
      s1_empty_string_r  <= in_empty_string;
    end
  end

  dsti_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .ctrl_i          (ctrl_r),
    .acc_i           (acc_r),
    .character_i     (s1_character_r),
    .radix_request_i (s1_radix_request_r),
    .last_char_i     (s1_last_char_r),
    .empty_string_i  (s1_empty_string_r),
    .ctrl_o          (ctrl_nxt),
    .acc_o           (acc_nxt),
    .emit_o          (step_emit),
    .value_o         (step_value),
    .status_o        (step_status)
  );

  // Parse state updates once per processed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= dsti_pkg::CTRL_RESET;
      acc_r  <= '0;
    end else if (s1_valid_r && advance) begin
      ctrl_r <= ctrl_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && step_emit) begin
      out_value_r  <= step_value;
      out_status_r <= step_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_value_r;
  assign out_parse_status = out_status_r;

  // Checks
  a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.chars_seen == 2'd0 |-> acc_r == '0 && !ctrl_r.error_flag &&
                                  !ctrl_r.negative_flag)
    else $error("parse state not clear between strings");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == dsti_pkg::STATUS_ERR |-> out_value_r == '0)
    else $error("invalid result carries a nonzero value");

  a_prefix_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.prefix_zero_pending |-> ctrl_r.active_radix == dsti_pkg::RADIX_DEC &&
                                   ctrl_r.chars_seen == 2'd1)
    else $error("prefix check pending outside the second character");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty input register");

endmodule
